@@ hdl/evc_pkg.sv @@
// ----------------------------------------------------------------------------
// evc_pkg: shared types and constants
// Verdict codes, position type, header layout and the item/result structs
// used by the extended-attribute chain validator.
// ----------------------------------------------------------------------------
`default_nettype none

package evc_pkg;

    localparam int POS_W = 17;

    typedef logic [POS_W-1:0] pos_t;

    typedef enum logic [1:0] {
        VERDICT_OK     = 2'd0,
        VERDICT_NAME   = 2'd1,
        VERDICT_BUFLEN = 2'd2,
        VERDICT_NEXT   = 2'd3
    } verdict_t;

    // header layout, byte positions within an entry
    localparam pos_t POS_NEXT_END   = pos_t'(4);
    localparam pos_t POS_Q_NAMELEN  = pos_t'(4);
    localparam pos_t POS_F_NAMELEN  = pos_t'(5);
    localparam pos_t POS_F_VLEN_LO  = pos_t'(6);
    localparam pos_t POS_F_VLEN_HI  = pos_t'(7);
    localparam pos_t HDR_QUERY      = pos_t'(5);
    localparam pos_t HDR_FULL       = pos_t'(8);
    localparam pos_t POS_MAX        = {POS_W{1'b1}};
    localparam pos_t PAD_MASK       = pos_t'(3);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        logic     valid;
        verdict_t verdict;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/ea_chain_validator.sv @@
// Path to the verdict: input register, parser logic, result register.
// Throughput: 1 byte per cycle; the parser consumes the input register
// whenever the result register is empty or being drained.
// At most one verdict per buffer; the byte with last_byte set ends the buffer.
// Reset: asynchronous, active low; clears parser state, both valid flags
// and list_kind (full entries).
// ----------------------------------------------------------------------------
// ea_chain_validator: extended-attribute chain validator
// Checks a chained attribute buffer streamed one byte per item and gives
// one verdict per buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module ea_chain_validator (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic       cfg_data,
    input  wire logic       in_valid,
    output      logic       in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    output      logic       out_valid,
    input  wire logic       out_stall,
    output      logic [1:0] verdict
);

    logic              list_kind_reg;
    logic              list_kind_next;
    logic              item_valid;
    evc_pkg::item_t    item;
    evc_pkg::result_t  result;
    logic              out_free;
    logic              advance;
    logic              out_valid_reg;
    logic              out_valid_next;
    evc_pkg::verdict_t verdict_reg;

    assign list_kind_next = cfg_write ? cfg_data : list_kind_reg;
    assign out_free       = !out_valid_reg || !out_stall;
    assign advance        = item_valid && out_free;

    evc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    evc_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (item),
        .list_kind (list_kind_reg),
        .result    (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_kind_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            list_kind_reg <= list_kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // load verdict when a result leaves the parser
    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            verdict_reg <= result.verdict;
        end
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

endmodule

`default_nettype wire

@@ hdl/evc_in_reg.sv @@
// ----------------------------------------------------------------------------
// evc_in_reg: input register
// Captures one buffer byte per cycle and holds it until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module evc_in_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output      logic          in_stall,
    input  wire logic [7:0]    data_byte,
    input  wire logic          last_byte,
    input  wire logic          advance,
    output      logic          item_valid,
    output      evc_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    evc_pkg::item_t item_reg;
    logic           accept;

    assign in_stall   = valid_reg && !advance;
    assign accept     = in_valid && !in_stall;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // load payload on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.data <= data_byte;
            item_reg.last <= last_byte;
        end
    end

endmodule

`default_nettype wire

@@ hdl/evc_parse.sv @@
// ----------------------------------------------------------------------------
// evc_parse: entry parser
// Holds the per-entry state, captures header fields and checks the name
// terminator, next offset and buffer end for one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module evc_parse (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire evc_pkg::item_t  item,
    input  wire logic            list_kind,
    output      evc_pkg::result_t result
);

    evc_pkg::pos_t pos_reg;
    evc_pkg::pos_t pos_next;
    logic [31:0]   no_reg;
    logic [31:0]   no_next;
    logic [7:0]    nl_reg;
    logic [7:0]    nl_next;
    logic [15:0]   vl_reg;
    logic [15:0]   vl_next;
    logic          fin_reg;
    logic          fin_next;
    logic          given_reg;
    logic          given_next;

    logic [31:0]   cap_no;
    logic [7:0]    cap_nl;
    logic [15:0]   cap_vl;
    evc_pkg::pos_t hdr;
    evc_pkg::pos_t term;
    evc_pkg::pos_t elen_raw;
    evc_pkg::pos_t elen;
    evc_pkg::pos_t elen_m1;
    logic          fin_cur;
    logic          have;
    evc_pkg::verdict_t verdict;

    // header field capture
    always_comb
    begin
        cap_no = no_reg;
        cap_nl = nl_reg;
        cap_vl = vl_reg;
        if (pos_reg < evc_pkg::POS_NEXT_END)
        begin
            case (pos_reg[1:0])
                2'd0:    cap_no[7:0]   = no_reg[7:0]   | item.data;
                2'd1:    cap_no[15:8]  = no_reg[15:8]  | item.data;
                2'd2:    cap_no[23:16] = no_reg[23:16] | item.data;
                2'd3:    cap_no[31:24] = no_reg[31:24] | item.data;
                default: cap_no = no_reg;
            endcase
        end
        else if (list_kind)
        begin
            if (pos_reg == evc_pkg::POS_Q_NAMELEN)
            begin
                cap_nl = item.data;
            end
        end
        else if (pos_reg == evc_pkg::POS_F_NAMELEN)
        begin
            cap_nl = item.data;
        end
        else if (pos_reg == evc_pkg::POS_F_VLEN_LO)
        begin
            cap_vl[7:0] = item.data;
        end
        else if (pos_reg == evc_pkg::POS_F_VLEN_HI)
        begin
            cap_vl[15:8] = item.data;
        end
    end

    assign hdr      = list_kind ? evc_pkg::HDR_QUERY : evc_pkg::HDR_FULL;
    assign term     = hdr + evc_pkg::pos_t'(cap_nl);
    assign elen_raw = term + evc_pkg::pos_t'(1)
                      + (list_kind ? evc_pkg::pos_t'(0) : evc_pkg::pos_t'(cap_vl));
    assign elen     = (elen_raw + evc_pkg::PAD_MASK) & ~evc_pkg::PAD_MASK;
    assign elen_m1  = elen - evc_pkg::pos_t'(1);

    // checks, in priority order
    always_comb
    begin
        have    = 1'b0;
        verdict = evc_pkg::VERDICT_OK;
        fin_cur = fin_reg;
        if (pos_reg >= hdr)
        begin
            if (pos_reg < term)
            begin
                if (item.data == 8'd0)
                begin
                    have    = 1'b1;
                    verdict = evc_pkg::VERDICT_NAME;
                end
            end
            else if (pos_reg == term)
            begin
                if (item.data != 8'd0)
                begin
                    have    = 1'b1;
                    verdict = evc_pkg::VERDICT_NAME;
                end
                else if (cap_no == 32'd0)
                begin
                    fin_cur = 1'b1;
                end
                else if (cap_no != 32'(elen))
                begin
                    have    = 1'b1;
                    verdict = evc_pkg::VERDICT_NEXT;
                end
            end
            else if (fin_reg && pos_reg >= elen)
            begin
                have    = 1'b1;
                verdict = evc_pkg::VERDICT_BUFLEN;
            end
        end
        if (!have && item.last)
        begin
            have    = 1'b1;
            verdict = (fin_cur && pos_reg == elen_m1) ? evc_pkg::VERDICT_OK
                                                      : evc_pkg::VERDICT_BUFLEN;
        end
    end

    // state update
    always_comb
    begin
        pos_next       = pos_reg;
        no_next        = no_reg;
        nl_next        = nl_reg;
        vl_next        = vl_reg;
        fin_next       = fin_reg;
        given_next     = given_reg;
        result.valid   = 1'b0;
        result.verdict = verdict;
        if (step)
        begin
            if (given_reg)
            begin
                if (item.last)
                begin
                    pos_next   = '0;
                    no_next    = '0;
                    nl_next    = '0;
                    vl_next    = '0;
                    fin_next   = 1'b0;
                    given_next = 1'b0;
                end
            end
            else if (have)
            begin
                result.valid = 1'b1;
                if (item.last)
                begin
                    pos_next   = '0;
                    no_next    = '0;
                    nl_next    = '0;
                    vl_next    = '0;
                    fin_next   = 1'b0;
                    given_next = 1'b0;
                end
                else
                begin
                    no_next    = cap_no;
                    nl_next    = cap_nl;
                    vl_next    = cap_vl;
                    fin_next   = fin_cur;
                    given_next = 1'b1;
                end
            end
            else if (!fin_cur && pos_reg >= term && pos_reg >= elen_m1)
            begin
                // advance to the next entry
                pos_next = '0;
                no_next  = '0;
                nl_next  = '0;
                vl_next  = '0;
                fin_next = 1'b0;
            end
            else
            begin
                no_next  = cap_no;
                nl_next  = cap_nl;
                vl_next  = cap_vl;
                fin_next = fin_cur;
                if (pos_reg != evc_pkg::POS_MAX)
                begin
                    pos_next = pos_reg + evc_pkg::pos_t'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            no_reg    <= '0;
            nl_reg    <= '0;
            vl_reg    <= '0;
            fin_reg   <= 1'b0;
            given_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            no_reg    <= no_next;
            nl_reg    <= nl_next;
            vl_reg    <= vl_next;
            fin_reg   <= fin_next;
            given_reg <= given_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/evc_checker.sv @@
// ----------------------------------------------------------------------------
// evc_checker: port-level checks
// Watches the validator's ports and flags handshake and flow slips.
// ----------------------------------------------------------------------------
`default_nettype none

module evc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [1:0] verdict
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(verdict))
        else $error("stalled verdict changed or dropped");

    // input stalls only behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while result path free");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid && !in_stall)
        else $error("output busy right after reset");

    // a result that appears after an empty output needs an item behind it
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without a source item");

endmodule

bind ea_chain_validator evc_checker u_evc_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for ea_chain_validator
// Streams attribute chains one byte per item in both entry layouts:
// well-formed chains, bad names and terminators, bad next offsets, short
// and overlong buffers, layout changes mid-buffer and raw noise. Verdicts
// are checked against a cycle-free parser model or the plan row's verdict.
// ----------------------------------------------------------------------------
module tb;

    localparam int DRAIN_CYCLES = 6;
    localparam int STALL_LIMIT  = 4000;
    localparam int PLAN_ROWS    = 18;
    localparam int PHASE_BYTES  = 85;
    localparam int PHASE_VERDICTS = 2;

    typedef enum logic [2:0] {
        FAULT_NONE,
        FAULT_NAME_ZERO,
        FAULT_TERM,
        FAULT_NEXT,
        FAULT_SHORT,
        FAULT_LONG,
        FAULT_SWITCH,
        FAULT_NOISE
    } chain_fault_t;

    typedef struct packed {
        logic              kind;
        logic [3:0]        n_ent;
        logic [7:0]        nlen;
        logic [15:0]       vlen;
        chain_fault_t      fault;
        logic              typed;
        evc_pkg::verdict_t want;
    } chain_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write = 1'b0;
    logic       cfg_data = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] verdict;

    // model of the parser
    logic        cv_kind;
    logic [16:0] cv_pos;
    logic [31:0] cv_next;
    logic [7:0]  cv_nlen;
    logic [15:0] cv_vlen;
    logic        cv_final;
    logic        cv_done;

    evc_pkg::verdict_t verdict_q [$];
    logic [7:0]        chain_bytes [$];
    chain_row_t        plan [0:PLAN_ROWS-1];

    bit                typed_en = 1'b0;
    evc_pkg::verdict_t typed_v = evc_pkg::VERDICT_OK;
    int                send_idle = 0;
    int                recv_idle = 0;
    int                bytes_sent = 0;
    int                verdicts_due = 0;
    int                verdicts_seen = 0;
    int                mism_cnt = 0;
    int                idle_cycles = 0;
    int                full_bufs = 0;
    int                query_bufs = 0;
    int                kind_writes = 0;

    ea_chain_validator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .verdict   (verdict)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_chain(input bit whole);
        cv_pos   = '0;
        cv_next  = '0;
        cv_nlen  = '0;
        cv_vlen  = '0;
        cv_final = 1'b0;
        if (whole)
            cv_done = 1'b0;
    endfunction

    function automatic bit predict_verdict(input logic [7:0] b, input logic last,
                                           output evc_pkg::verdict_t v);
        int unsigned pos;
        int unsigned hdr;
        int unsigned term;
        int unsigned elen;
        bit          q;
        bit          hit;
        v = evc_pkg::VERDICT_OK;
        hit = 1'b0;
        if (cv_done)
        begin
            if (last)
                clear_chain(1'b1);
            return 1'b0;
        end
        q = cv_kind;
        pos = cv_pos;
        hdr = q ? 5 : 8;
        if (pos < 4)
            cv_next = cv_next | (32'(b) << (8 * pos));
        else if (q)
        begin
            if (pos == 4)
                cv_nlen = b;
        end
        else if (pos == 5)
            cv_nlen = b;
        else if (pos == 6)
            cv_vlen[7:0] = b;
        else if (pos == 7)
            cv_vlen[15:8] = b;
        term = hdr + cv_nlen;
        elen = term + 1 + (q ? 0 : cv_vlen);
        elen = (elen + 3) & 32'hFFFF_FFFC;
        if (pos >= hdr)
        begin
            if (pos < term)
            begin
                if (b == 8'h00)
                begin
                    hit = 1'b1;
                    v = evc_pkg::VERDICT_NAME;
                end
            end
            else if (pos == term)
            begin
                if (b != 8'h00)
                begin
                    hit = 1'b1;
                    v = evc_pkg::VERDICT_NAME;
                end
                else if (cv_next == 32'd0)
                    cv_final = 1'b1;
                else if (cv_next != elen)
                begin
                    hit = 1'b1;
                    v = evc_pkg::VERDICT_NEXT;
                end
            end
            else if (cv_final && pos >= elen)
            begin
                hit = 1'b1;
                v = evc_pkg::VERDICT_BUFLEN;
            end
        end
        if (!hit && last)
        begin
            hit = 1'b1;
            v = (cv_final && pos == elen - 1) ? evc_pkg::VERDICT_OK
                                              : evc_pkg::VERDICT_BUFLEN;
        end
        if (hit)
        begin
            if (last)
                clear_chain(1'b1);
            else
                cv_done = 1'b1;
            return 1'b1;
        end
        if (!cv_final && pos >= term && pos >= elen - 1)
            clear_chain(1'b0);
        else if (pos < 32'h1FFFF)
            cv_pos = cv_pos + 1'b1;
        return 1'b0;
    endfunction

    function automatic int pick_len(input int maxv);
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(8);
        if (r < 95)
            return $urandom_range(40);
        return $urandom_range(maxv);
    endfunction

    // hold the item until accepted; valid stays high on return
    task automatic push_byte(input logic [7:0] b, input logic l);
        evc_pkg::verdict_t pv;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
        if (predict_verdict(b, l, pv))
        begin
            verdict_q.push_back(typed_en ? typed_v : pv);
            verdicts_due++;
        end
    endtask

    // drain the block, then write list_kind
    task automatic set_list_kind(input logic k);
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= k;
        @(posedge clk);
        cfg_write <= 1'b0;
        cv_kind = k;
        kind_writes++;
    endtask

    task automatic build_chain(input logic q, input int n_ent, input int nl_fix,
                               input int vl_fix, input chain_fault_t fault);
        int          ent_start [$];
        int          ent_nlen [$];
        int          ent_elen [$];
        int          e;
        int          k;
        int          nl;
        int          vl;
        int          hdr;
        int          elen;
        int          st;
        int          cut;
        logic [31:0] nxt;
        chain_bytes.delete();
        hdr = q ? 5 : 8;
        for (e = 0; e < n_ent; e++)
        begin
            nl = (nl_fix >= 0) ? nl_fix : pick_len(255);
            vl = q ? 0 : ((vl_fix >= 0) ? vl_fix : pick_len(300));
            elen = (hdr + nl + 1 + vl + 3) & ~3;
            nxt = (e == n_ent - 1) ? 32'd0 : 32'(elen);
            st = chain_bytes.size();
            for (k = 0; k < 4; k++)
                chain_bytes.push_back(nxt[8*k +: 8]);
            if (!q)
            begin
                chain_bytes.push_back(8'($urandom_range(255)));
                chain_bytes.push_back(8'(nl));
                chain_bytes.push_back(8'(vl));
                chain_bytes.push_back(8'(vl >> 8));
            end
            else
                chain_bytes.push_back(8'(nl));
            for (k = 0; k < nl; k++)
                chain_bytes.push_back(8'($urandom_range(1, 255)));
            chain_bytes.push_back(8'h00);
            while (chain_bytes.size() < st + elen)
                chain_bytes.push_back(8'($urandom_range(255)));
            ent_start.push_back(st);
            ent_nlen.push_back(nl);
            ent_elen.push_back(elen);
        end
        e = $urandom_range(n_ent - 1);
        st = ent_start[e];
        case (fault)
            FAULT_NAME_ZERO:
            begin
                if (ent_nlen[e] > 0)
                    chain_bytes[st + hdr + $urandom_range(ent_nlen[e] - 1)] = 8'h00;
                else
                    chain_bytes[st + hdr] = 8'($urandom_range(1, 255));
            end
            FAULT_TERM:
                chain_bytes[st + hdr + ent_nlen[e]] = 8'($urandom_range(1, 255));
            FAULT_NEXT:
            begin
                nxt = $urandom;
                if (nxt == 32'd0 || nxt == 32'(ent_elen[e]))
                    nxt = 32'(ent_elen[e] + 4);
                for (k = 0; k < 4; k++)
                    chain_bytes[st + k] = nxt[8*k +: 8];
            end
            FAULT_SHORT:
            begin
                cut = $urandom_range(1, chain_bytes.size() - 1);
                while (chain_bytes.size() > cut)
                    void'(chain_bytes.pop_back());
            end
            FAULT_LONG:
            begin
                cut = $urandom_range(1, 5);
                for (k = 0; k < cut; k++)
                    chain_bytes.push_back(8'($urandom_range(255)));
            end
            FAULT_NOISE:
            begin
                chain_bytes.delete();
                cut = $urandom_range(1, 40);
                for (k = 0; k < cut; k++)
                    chain_bytes.push_back(8'($urandom_range(255)));
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_chain(input int switch_at);
        int i;
        if (cv_kind)
            query_bufs++;
        else
            full_bufs++;
        for (i = 0; i < chain_bytes.size(); i++)
        begin
            if (i == switch_at)
                set_list_kind(!cv_kind);
            push_byte(chain_bytes[i], i == chain_bytes.size() - 1);
        end
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            verdicts_seen++;
            if (verdict_q.size() == 0)
            begin
                mism_cnt++;
                if (mism_cnt <= 10)
                    $display("unexpected verdict %0d", verdict);
            end
            else if (verdict !== verdict_q[0])
            begin
                mism_cnt++;
                if (mism_cnt <= 10)
                    $display("verdict %0d: expected %0d, got %0d",
                             verdicts_seen, verdict_q[0], verdict);
                void'(verdict_q.pop_front());
            end
            else
                void'(verdict_q.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("stalled for %0d cycles, %0d verdicts pending",
                     idle_cycles, verdict_q.size());
            $display("ea_chain_validator: mismatch");
            $finish;
        end
    end

    initial
    begin
        int           r;
        int           ph;
        int           ph_bytes;
        int           ph_due;
        chain_fault_t fault;
        chain_row_t   row;

        plan = '{
            '{1'b0, 4'd1, 8'd0,   16'd0, FAULT_NONE,      1'b1, evc_pkg::VERDICT_OK},
            '{1'b0, 4'd1, 8'd255, 16'd0, FAULT_NONE,      1'b1, evc_pkg::VERDICT_OK},
            '{1'b0, 4'd1, 8'd6,   16'd1, FAULT_NONE,      1'b1, evc_pkg::VERDICT_OK},
            '{1'b1, 4'd1, 8'd0,   16'd0, FAULT_NONE,      1'b1, evc_pkg::VERDICT_OK},
            '{1'b1, 4'd1, 8'd2,   16'd0, FAULT_NONE,      1'b1, evc_pkg::VERDICT_OK},
            '{1'b0, 4'd3, 8'd3,   16'd5, FAULT_NONE,      1'b1, evc_pkg::VERDICT_OK},
            '{1'b1, 4'd3, 8'd2,   16'd0, FAULT_NONE,      1'b1, evc_pkg::VERDICT_OK},
            '{1'b0, 4'd2, 8'd4,   16'd2, FAULT_NAME_ZERO, 1'b1, evc_pkg::VERDICT_NAME},
            '{1'b1, 4'd1, 8'd3,   16'd0, FAULT_TERM,      1'b1, evc_pkg::VERDICT_NAME},
            '{1'b0, 4'd2, 8'd1,   16'd3, FAULT_NEXT,      1'b1, evc_pkg::VERDICT_NEXT},
            '{1'b1, 4'd2, 8'd2,   16'd0, FAULT_NEXT,      1'b1, evc_pkg::VERDICT_NEXT},
            '{1'b0, 4'd2, 8'd2,   16'd1, FAULT_SHORT,     1'b1, evc_pkg::VERDICT_BUFLEN},
            '{1'b1, 4'd1, 8'd0,   16'd0, FAULT_SHORT,     1'b1, evc_pkg::VERDICT_BUFLEN},
            '{1'b0, 4'd1, 8'd2,   16'd0, FAULT_LONG,      1'b1, evc_pkg::VERDICT_BUFLEN},
            '{1'b1, 4'd2, 8'd1,   16'd0, FAULT_LONG,      1'b1, evc_pkg::VERDICT_BUFLEN},
            '{1'b0, 4'd1, 8'd4,   16'd4, FAULT_SWITCH,    1'b0, evc_pkg::VERDICT_OK},
            '{1'b0, 4'd1, 8'd0,   16'd0, FAULT_NOISE,     1'b0, evc_pkg::VERDICT_OK},
            '{1'b1, 4'd1, 8'd0,   16'd0, FAULT_NOISE,     1'b0, evc_pkg::VERDICT_OK}
        };
        cv_kind = 1'b0;
        cv_done = 1'b0;
        clear_chain(1'b1);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 15;
        recv_idle = 64;
        for (r = 0; r < PLAN_ROWS; r++)
        begin
            row = plan[r];
            if (row.kind != cv_kind)
                set_list_kind(row.kind);
            build_chain(row.kind, row.n_ent, row.nlen, row.vlen, row.fault);
            typed_en = row.typed;
            typed_v = row.want;
            send_chain(row.fault == FAULT_SWITCH ?
                       $urandom_range(1, chain_bytes.size() - 1) : -1);
            typed_en = 1'b0;
        end

        for (ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 15 : (ph == 1) ? 64 : 0;
            recv_idle = (ph == 0) ? 64 : (ph == 1) ? 15 : 0;
            set_list_kind(ph == 1);
            ph_bytes = bytes_sent;
            ph_due = verdicts_due;
            while (bytes_sent - ph_bytes < PHASE_BYTES ||
                   verdicts_due - ph_due < PHASE_VERDICTS)
            begin
                if ($urandom_range(9) == 0)
                    set_list_kind(!cv_kind);
                r = $urandom_range(99);
                if (r < 50)
                    fault = FAULT_NONE;
                else if (r < 58)
                    fault = FAULT_NAME_ZERO;
                else if (r < 66)
                    fault = FAULT_TERM;
                else if (r < 74)
                    fault = FAULT_NEXT;
                else if (r < 82)
                    fault = FAULT_SHORT;
                else if (r < 90)
                    fault = FAULT_LONG;
                else if (r < 95)
                    fault = FAULT_SWITCH;
                else
                    fault = FAULT_NOISE;
                build_chain(cv_kind, $urandom_range(1, 3), -1, -1, fault);
                send_chain(fault == FAULT_SWITCH ?
                           $urandom_range(1, chain_bytes.size() - 1) : -1);
            end
        end

        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (2 * DRAIN_CYCLES) @(posedge clk);

        $display("%0d bytes in %0d full-entry and %0d query buffers, %0d verdicts checked",
                 bytes_sent, full_bufs, query_bufs, verdicts_seen);
        $display("%0d list_kind writes, three idling phases", kind_writes);
        if (mism_cnt == 0 && verdict_q.size() == 0)
            $display("ea_chain_validator: match");
        else
            $display("ea_chain_validator: mismatch");
        $finish;
    end

endmodule
